// ===== rtl/core/sha512f_pkg.sv =====
// sha512f_pkg: constants, types and round functions for the SHA-512 family hash.
// No dependencies.
`timescale 1ns / 1ps
package sha512f_pkg;
	localparam int WordW = 64;
	localparam int Rounds = 80;

	localparam logic [1:0] VAR_SHA512 = 2'd0;
	localparam logic [1:0] VAR_SHA384 = 2'd1;
	localparam logic [1:0] VAR_SHA224 = 2'd2;
	localparam logic [1:0] VAR_SHA256 = 2'd3;

	// datapath commands
	localparam logic [2:0] CMD_NONE  = 3'd0;
	localparam logic [2:0] CMD_INIT  = 3'd1; // load IV, clear length
	localparam logic [2:0] CMD_PUSH  = 3'd2; // write buffer word
	localparam logic [2:0] CMD_START = 3'd3; // copy hash to working vars
	localparam logic [2:0] CMD_ROUND = 3'd4;
	localparam logic [2:0] CMD_FOLD  = 3'd5; // add working vars into hash

	// source of the pushed word
	localparam logic [1:0] SRC_DATA = 2'd0;
	localparam logic [1:0] SRC_ZERO = 2'd1;
	localparam logic [1:0] SRC_LENH = 2'd2;
	localparam logic [1:0] SRC_LENL = 2'd3;

	typedef struct packed {
		logic [2:0]  op;
		logic [1:0]  src;
		logic [3:0]  widx;  // buffer slot for push
		logic [6:0]  rnd;   // round number
		logic [2:0]  oidx;  // digest word to show
		logic        addlen;
		logic [6:0]  addbits;
	} sha512f_cmd_t;

	function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
		rotr = (x >> n) | (x << (64 - n));
	endfunction

	function automatic logic [63:0] iv(input logic [1:0] v, input logic [2:0] i);
		logic [63:0] t [4][8];
		t[0] = '{64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
			64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
			64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};
		t[1] = '{64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17,
			64'h152fecd8f70e5939, 64'h67332667ffc00b31, 64'h8eb44a8768581511,
			64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4};
		t[2] = '{64'h8C3D37C819544DA2, 64'h73E1996689DCD4D6, 64'h1DFAB7AE32FF9C82,
			64'h679DD514582F9FCF, 64'h0F6D2B697BD44DA8, 64'h77E36F7304C48942,
			64'h3F9D85A86A1D36C8, 64'h1112E6AD91D692A1};
		t[3] = '{64'h22312194FC2BF72C, 64'h9F555FA3C84C64C2, 64'h2393B86B6F53B151,
			64'h963877195940EABD, 64'h96283EE2A88EFFE3, 64'hBE5E1E2553863992,
			64'h2B0199FC2C85B8AA, 64'h0EB72DDC81C52CA2};
		iv = t[v][i];
	endfunction

	function automatic logic [3:0] digest_len(input logic [1:0] v);
		unique case (v)
			VAR_SHA512: digest_len = 4'd8;
			VAR_SHA384: digest_len = 4'd6;
			default:    digest_len = 4'd4;
		endcase
	endfunction

	function automatic logic [63:0] round_k(input logic [6:0] i);
		logic [63:0] k [80];
		k = '{
		64'h428A2F98D728AE22, 64'h7137449123EF65CD, 64'hB5C0FBCFEC4D3B2F, 64'hE9B5DBA58189DBBC,
		64'h3956C25BF348B538, 64'h59F111F1B605D019, 64'h923F82A4AF194F9B, 64'hAB1C5ED5DA6D8118,
		64'hD807AA98A3030242, 64'h12835B0145706FBE, 64'h243185BE4EE4B28C, 64'h550C7DC3D5FFB4E2,
		64'h72BE5D74F27B896F, 64'h80DEB1FE3B1696B1, 64'h9BDC06A725C71235, 64'hC19BF174CF692694,
		64'hE49B69C19EF14AD2, 64'hEFBE4786384F25E3, 64'h0FC19DC68B8CD5B5, 64'h240CA1CC77AC9C65,
		64'h2DE92C6F592B0275, 64'h4A7484AA6EA6E483, 64'h5CB0A9DCBD41FBD4, 64'h76F988DA831153B5,
		64'h983E5152EE66DFAB, 64'hA831C66D2DB43210, 64'hB00327C898FB213F, 64'hBF597FC7BEEF0EE4,
		64'hC6E00BF33DA88FC2, 64'hD5A79147930AA725, 64'h06CA6351E003826F, 64'h142929670A0E6E70,
		64'h27B70A8546D22FFC, 64'h2E1B21385C26C926, 64'h4D2C6DFC5AC42AED, 64'h53380D139D95B3DF,
		64'h650A73548BAF63DE, 64'h766A0ABB3C77B2A8, 64'h81C2C92E47EDAEE6, 64'h92722C851482353B,
		64'hA2BFE8A14CF10364, 64'hA81A664BBC423001, 64'hC24B8B70D0F89791, 64'hC76C51A30654BE30,
		64'hD192E819D6EF5218, 64'hD69906245565A910, 64'hF40E35855771202A, 64'h106AA07032BBD1B8,
		64'h19A4C116B8D2D0C8, 64'h1E376C085141AB53, 64'h2748774CDF8EEB99, 64'h34B0BCB5E19B48A8,
		64'h391C0CB3C5C95A63, 64'h4ED8AA4AE3418ACB, 64'h5B9CCA4F7763E373, 64'h682E6FF3D6B2B8A3,
		64'h748F82EE5DEFB2FC, 64'h78A5636F43172F60, 64'h84C87814A1F0AB72, 64'h8CC702081A6439EC,
		64'h90BEFFFA23631E28, 64'hA4506CEBDE82BDE9, 64'hBEF9A3F7B2C67915, 64'hC67178F2E372532B,
		64'hCA273ECEEA26619C, 64'hD186B8C721C0C207, 64'hEADA7DD6CDE0EB1E, 64'hF57D4F7FEE6ED178,
		64'h06F067AA72176FBA, 64'h0A637DC5A2C898A6, 64'h113F9804BEF90DAE, 64'h1B710B35131C471B,
		64'h28DB77F523047D84, 64'h32CAAB7B40C72493, 64'h3C9EBE0A15C9BEBC, 64'h431D67C49C100D4C,
		64'h4CC5D4BECB3E42B6, 64'h597F299CFC657E2A, 64'h5FCB6FAB3AD6FAEC, 64'h6C44198C4A475817};
		round_k = k[i];
	endfunction
endpackage

// ===== rtl/core/sha512f_if.sv =====
// sha512f_in_if / sha512f_out_if: valid/ready channels of the hash block.
// Depends on nothing.
`timescale 1ns / 1ps
interface sha512f_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] data_word;
	logic [3:0]  byte_count;
	logic        last;
	modport source (output valid, data_word, byte_count, last, input ready);
	modport sink (input valid, data_word, byte_count, last, output ready);
endinterface

interface sha512f_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] digest_word;
	logic [3:0]  digest_bytes;
	logic        digest_end;
	modport source (output valid, digest_word, digest_bytes, digest_end, input ready);
	modport sink (input valid, digest_word, digest_bytes, digest_end, output ready);
endinterface

// ===== rtl/core/sha512_family_hash.sv =====
// sha512_family_hash: top level, APB register and channel wiring.
// Depends on sha512f_pkg, sha512f_if, sha512f_ctrl, sha512f_datapath.
`timescale 1ns / 1ps
// SHA-512 / SHA-384 / SHA-512/224 / SHA-512/256 engine. Message words arrive as
// big-endian 64-bit requests; only the one flagged last may be partial. One request
// is taken per cycle while the 16-word buffer fills; each full block then runs the
// 80 compression rounds at one round a cycle between a set-up step and a fold step.
// After the last word the padding words are written one per cycle and one or two
// final blocks compress, then the 4, 6 or 8 digest words are offered one per
// cycle while out_ch.ready is high. The variant register (address 0) selects
// IV and digest length; writing it abandons any message in progress and
// reloads the IV.
module sha512_family_hash (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	sha512f_in_if.sink          in_ch,
	sha512f_out_if.source       out_ch
);
	import sha512f_pkg::*;

	logic [1:0]   variant_q;
	logic         cfg_wr;
	logic         out_mask;
	logic [63:0]  push_data;
	logic [63:0]  len_hi, len_lo, hash_out;
	sha512f_cmd_t cmd;

	assign pready = 1'b1;
	// writes beyond register 0 are ignored
	assign cfg_wr = psel && penable && pwrite && (paddr == 3'd0);
	assign prdata = (paddr == 3'd0) ? {30'd0, variant_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) variant_q <= VAR_SHA512;
		else if (cfg_wr) variant_q <= pwdata[1:0];
	end

	sha512f_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .cfg_wr(cfg_wr), .variant(variant_q),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_count(in_ch.byte_count),
		.in_last(in_ch.last), .in_data(in_ch.data_word), .push_data(push_data),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.out_bytes(out_ch.digest_bytes), .out_end(out_ch.digest_end),
		.out_mask(out_mask), .cmd(cmd)
	);

	// the datapath sees the new variant during the INIT of a config write
	sha512f_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.variant(cfg_wr ? pwdata[1:0] : variant_q), .push_data(push_data),
		.len_hi(len_hi), .len_lo(len_lo), .hash_out(hash_out)
	);

	assign out_ch.digest_word = out_mask ? {hash_out[63:32], 32'd0} : hash_out;
endmodule

// ===== rtl/core/sha512f_datapath.sv =====
// sha512f_datapath: block buffer, message schedule, round logic, hash words, length.
// Depends on sha512f_pkg.
`timescale 1ns / 1ps
module sha512f_datapath (
	input  logic                      clk,
	input  logic                      arst_n,
	input  sha512f_pkg::sha512f_cmd_t cmd,
	input  logic [1:0]                variant,
	input  logic [63:0]               push_data,
	output logic [63:0]               len_hi,
	output logic [63:0]               len_lo,
	output logic [63:0]               hash_out
);
	import sha512f_pkg::*;

	logic [63:0] w_q [16];  // sliding schedule window, w_q[0] = W[t]
	logic [63:0] h_q [8];
	logic [63:0] v_q [8];
	logic [63:0] pushed;
	logic [63:0] s0, s1, wnext, t1, t2, e, a;

	always_comb begin
		unique case (cmd.src)
			SRC_DATA: pushed = push_data;
			SRC_ZERO: pushed = '0;
			SRC_LENH: pushed = len_hi;
			SRC_LENL: pushed = len_lo;
		endcase
		s0 = rotr(w_q[1], 1) ^ rotr(w_q[1], 8) ^ (w_q[1] >> 7);
		s1 = rotr(w_q[14], 19) ^ rotr(w_q[14], 61) ^ (w_q[14] >> 6);
		wnext = s1 + w_q[9] + s0 + w_q[0];
		e = v_q[4];
		a = v_q[0];
		t1 = v_q[7] + (rotr(e, 14) ^ rotr(e, 18) ^ rotr(e, 41))
			+ ((e & v_q[5]) ^ (~e & v_q[6])) + round_k(cmd.rnd) + w_q[0];
		t2 = (rotr(a, 28) ^ rotr(a, 34) ^ rotr(a, 39))
			+ ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	always_ff @(posedge clk) begin
		if (cmd.op == CMD_PUSH) begin
			w_q[cmd.widx] <= pushed;
		end else if (cmd.op == CMD_ROUND) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
			w_q[15] <= wnext;
		end
		if (cmd.op == CMD_START) begin
			v_q <= h_q;
		end else if (cmd.op == CMD_ROUND) begin
			v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) h_q[i] <= iv(VAR_SHA512, 3'(i));
			len_hi <= '0;
			len_lo <= '0;
		end else begin
			if (cmd.op == CMD_INIT) begin
				for (int i = 0; i < 8; i++) h_q[i] <= iv(variant, 3'(i));
				len_hi <= '0;
				len_lo <= '0;
			end else begin
				if (cmd.op == CMD_FOLD) begin
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
				end
				if (cmd.addlen) begin
					{len_hi, len_lo} <= {len_hi, len_lo} + 128'(cmd.addbits);
				end
			end
		end
	end

	assign hash_out = h_q[cmd.oidx];
endmodule

// ===== rtl/core/sha512f_ctrl.sv =====
// sha512f_ctrl: sequencer for buffering, padding, compression and digest output.
// Depends on sha512f_pkg.
`timescale 1ns / 1ps
module sha512f_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr,
	input  logic [1:0]                variant,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [3:0]                in_count,
	input  logic                      in_last,
	input  logic [63:0]               in_data,
	output logic [63:0]               push_data,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [3:0]                out_bytes,
	output logic                      out_end,
	output logic                      out_mask,
	output sha512f_pkg::sha512f_cmd_t cmd
);
	import sha512f_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PAD  = 3'd1; // push zeros / length
	localparam logic [2:0] ST_START = 3'd2;
	localparam logic [2:0] ST_RND  = 3'd3;
	localparam logic [2:0] ST_FOLD = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;
	localparam logic [2:0] ST_MARK = 3'd6; // push 0x80 word after full last word

	logic [2:0] state_q;
	logic [3:0] cnt_q;    // buffered words
	logic [6:0] rnd_q;
	logic [2:0] oidx_q;
	logic       fin_q;    // in final padding sequence
	logic       mark_q;   // 0x80 word still owed after a full block
	logic       lenpushed_q;
	logic [3:0] cnt_sat;
	logic [63:0] mask, padded;
	logic       take;
	logic       full;

	assign cnt_sat = (in_count > 4'd8) ? 4'd8 : in_count;
	always_comb begin
		mask = (cnt_sat == 4'd0) ? 64'd0 : ~(64'hFFFF_FFFF_FFFF_FFFF >> (7'(cnt_sat) * 7'd8));
		padded = (in_data & mask) | (64'h8000_0000_0000_0000 >> (7'(cnt_sat) * 7'd8));
	end

	assign in_ready = (state_q == ST_IDLE) && !cfg_wr;
	assign take = in_valid && in_ready && !cfg_wr;
	assign full = (cnt_q == 4'd15);
	assign out_valid = (state_q == ST_OUT);
	assign out_end = (4'({1'b0, oidx_q}) == digest_len(variant) - 4'd1);
	assign out_mask = out_end && (variant == VAR_SHA224);
	assign out_bytes = out_mask ? 4'd4 : 4'd8;

	always_comb begin
		cmd = '0;
		cmd.widx = cnt_q;
		cmd.rnd = rnd_q;
		cmd.oidx = oidx_q;
		cmd.src = SRC_ZERO;
		push_data = in_data;
		if (cfg_wr) begin
			cmd.op = CMD_INIT;
		end else begin
			unique case (state_q)
				ST_IDLE: if (take) begin
					cmd.op = CMD_PUSH;
					cmd.src = SRC_DATA;
					cmd.addlen = 1'b1;
					cmd.addbits = in_last ? 7'(cnt_sat) * 7'd8 : 7'd64;
					if (in_last && cnt_sat != 4'd8) push_data = padded;
				end
				ST_MARK: begin
					cmd.op = CMD_PUSH;
					cmd.src = SRC_DATA;
					push_data = 64'h8000_0000_0000_0000;
				end
				ST_PAD: begin
					cmd.op = CMD_PUSH;
					// slot 15 takes the low length only after the high one went in slot 14
					cmd.src = (cnt_q == 4'd14) ? SRC_LENH :
						(cnt_q == 4'd15 && lenpushed_q) ? SRC_LENL : SRC_ZERO;
				end
				ST_START: cmd.op = CMD_START;
				ST_RND:   cmd.op = CMD_ROUND;
				ST_FOLD:  cmd.op = CMD_FOLD;
				ST_OUT: if (out_ready && out_end) cmd.op = CMD_INIT;
				default: cmd.op = CMD_NONE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			rnd_q <= '0;
			oidx_q <= '0;
			fin_q <= 1'b0;
			mark_q <= 1'b0;
		end else if (cfg_wr) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			rnd_q <= '0;
			oidx_q <= '0;
			fin_q <= 1'b0;
			mark_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (take) begin
					cnt_q <= cnt_q + 4'd1;
					fin_q <= in_last;
					if (in_last && cnt_sat == 4'd8) begin
						if (full) begin
							state_q <= ST_START;
							mark_q <= 1'b1;
						end else state_q <= ST_MARK;
					end
					else if (full) state_q <= ST_START;
					else if (in_last) state_q <= ST_PAD;
				end
				ST_MARK: begin
					cnt_q <= cnt_q + 4'd1;
					state_q <= full ? ST_START : ST_PAD;
				end
				ST_PAD: begin
					cnt_q <= cnt_q + 4'd1;
					if (full) state_q <= ST_START;
				end
				ST_START: begin
					rnd_q <= '0;
					state_q <= ST_RND;
				end
				ST_RND: begin
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == 7'(Rounds - 1)) state_q <= ST_FOLD;
				end
				ST_FOLD: begin
					// final block is the one that took the length words
					if (!fin_q) state_q <= ST_IDLE;
					else if (cnt_q == 4'd0 && lenpushed_q) begin
						state_q <= ST_OUT;
						oidx_q <= '0;
					end else if (mark_q) begin
						state_q <= ST_MARK;
						mark_q <= 1'b0;
					end else state_q <= ST_PAD;
				end
				ST_OUT: if (out_ready) begin
					oidx_q <= oidx_q + 3'd1;
					if (out_end) begin
						state_q <= ST_IDLE;
						fin_q <= 1'b0;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// set once the high length word goes in; the low one follows next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) lenpushed_q <= 1'b0;
		else if (cfg_wr || state_q == ST_OUT) lenpushed_q <= 1'b0;
		else if (state_q == ST_PAD && cnt_q == 4'd14) lenpushed_q <= 1'b1;
	end

	a_out_only_in_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> fin_q) else $error("digest shown outside final sequence");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ready) else $error("input taken while busy");
	a_rounds_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RND && rnd_q == 7'(Rounds - 1) && !cfg_wr) |=> state_q == ST_FOLD)
		else $error("round count overrun");
endmodule
